// ===== src/cfp_pkg.sv =====
// cfp_pkg: command and status codes, field widths and shared types for the
// circular fifo with peek; no dependencies
`default_nettype none

package cfp_pkg;

  localparam int CMD_W    = 3;
  localparam int OFFSET_W = 8;
  localparam int COUNT_W  = 9;
  localparam int CAP_W    = 9;
  localparam int LEN_W    = 9;

  localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FLUSH   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DISCARD = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RUN     = 3'd5;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } result_code_t;

  // side information of one command between decode and the result register
  typedef struct packed {
    result_code_t     status;
    logic             rd;
    logic [LEN_W-1:0] run_length;
    logic [LEN_W-1:0] fill_level;
    logic             overflow_seen;
  } s1_t;

endpackage

`default_nettype wire

// ===== src/cfp_if.sv =====
// cfp_req_if / cfp_rsp_if: valid/ready channels for commands and results
// depends on cfp_pkg
`default_nettype none

interface cfp_req_if #(
  parameter int ELEMENT_WIDTH = 8
);
  logic                          valid;
  logic                          ready;
  logic [cfp_pkg::CMD_W-1:0]     command;
  logic [ELEMENT_WIDTH-1:0]      data_in;
  logic [cfp_pkg::OFFSET_W-1:0]  offset;
  logic [cfp_pkg::COUNT_W-1:0]   count;

  modport source (output valid, command, data_in, offset, count, input ready);
  modport sink   (input valid, command, data_in, offset, count, output ready);
endinterface

interface cfp_rsp_if #(
  parameter int ELEMENT_WIDTH = 8
);
  logic                       valid;
  logic                       ready;
  cfp_pkg::result_code_t      status;
  logic [ELEMENT_WIDTH-1:0]   data_out;
  logic [cfp_pkg::LEN_W-1:0]  run_length;
  logic [cfp_pkg::LEN_W-1:0]  fill_level;
  logic                       overflow_seen;

  modport source (output valid, status, data_out, run_length, fill_level, overflow_seen,
                  input ready);
  modport sink   (input valid, status, data_out, run_length, fill_level, overflow_seen,
                  output ready);
endinterface

`default_nettype wire

// ===== src/cfp_ram.sv =====
// cfp_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module cfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/cfp_ctrl.sv =====
// cfp_ctrl: pointers, occupancy, capacity and command decode; owns the slot ram
// depends on cfp_pkg and cfp_ram
`default_nettype none

module cfp_ctrl #(
  parameter int DEPTH         = 256,
  parameter int ELEMENT_WIDTH = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [cfp_pkg::CAP_W-1:0]     cfg_wr_data,
  input  wire logic                          accept,
  input  wire logic [cfp_pkg::CMD_W-1:0]     command,
  input  wire logic [ELEMENT_WIDTH-1:0]      data_in,
  input  wire logic [cfp_pkg::OFFSET_W-1:0]  offset,
  input  wire logic [cfp_pkg::COUNT_W-1:0]   count,
  output cfp_pkg::s1_t                       s1,
  output logic      [ELEMENT_WIDTH-1:0]      rd_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > cfp_pkg::LEN_W) ? CW : cfp_pkg::LEN_W) + 1;

  logic [PW-1:0] wp, wp_next;
  logic [PW-1:0] rp, rp_next;
  logic [CW-1:0] occ, occ_next;
  logic          ovf, ovf_next;
  logic [CW-1:0] cap, cfg_cap;
  logic [XW-1:0] capx, occx, cfg_x, run_x;
  logic          ram_we, ram_re;
  logic [PW-1:0] ram_raddr;
  cfp_pkg::s1_t  s1_next;

  // position + n, wrapped at the active capacity (pos < cap, n <= cap)
  function automatic logic [PW-1:0] adv(input logic [PW-1:0] pos, input logic [XW-1:0] n,
                                        input logic [XW-1:0] c);
    logic [XW-1:0] p;
    p = XW'(pos) + n;
    if (p >= c) begin
      p = p - c;
    end
    return p[PW-1:0];
  endfunction

  assign capx  = XW'(cap);
  assign occx  = XW'(occ);
  assign cfg_x = XW'(cfg_wr_data);

  // zero acts as one, anything above the storage depth acts as the depth
  always_comb begin
    priority if (cfg_x == '0) begin
      cfg_cap = CW'(1);
    end else if (cfg_x > XW'(DEPTH)) begin
      cfg_cap = CW'(DEPTH);
    end else begin
      cfg_cap = cfg_x[CW-1:0];
    end
  end

  always_comb begin
    wp_next   = wp;
    rp_next   = rp;
    occ_next  = occ;
    ovf_next  = ovf;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = rp;
    run_x     = '0;
    s1_next.status = cfp_pkg::ST_OK;
    s1_next.rd     = 1'b0;
    unique case (command)
      cfp_pkg::CMD_PUSH: begin
        if (occx >= capx) begin
          ovf_next       = 1'b1;
          s1_next.status = cfp_pkg::ST_OVERFLOW;
        end else begin
          ram_we   = 1'b1;
          wp_next  = adv(wp, XW'(1), capx);
          occ_next = occ + CW'(1);
        end
      end
      cfp_pkg::CMD_POP: begin
        if (occ == '0) begin
          s1_next.status = cfp_pkg::ST_UNDERFLOW;
        end else begin
          ram_re     = 1'b1;
          s1_next.rd = 1'b1;
          rp_next    = adv(rp, XW'(1), capx);
          occ_next   = occ - CW'(1);
        end
      end
      cfp_pkg::CMD_PEEK: begin
        if (occx <= XW'(offset)) begin
          s1_next.status = cfp_pkg::ST_UNDERFLOW;
        end else begin
          ram_re     = 1'b1;
          s1_next.rd = 1'b1;
          ram_raddr  = adv(rp, XW'(offset), capx);
        end
      end
      cfp_pkg::CMD_FLUSH: begin
        wp_next  = '0;
        rp_next  = '0;
        occ_next = '0;
        ovf_next = 1'b0;
      end
      cfp_pkg::CMD_DISCARD: begin
        if (XW'(count) > occx) begin
          s1_next.status = cfp_pkg::ST_UNDERFLOW;
        end else begin
          rp_next  = adv(rp, XW'(count), capx);
          occ_next = CW'(occx - XW'(count));
        end
      end
      cfp_pkg::CMD_RUN: begin
        if (occ != '0) begin
          priority if (wp > rp) begin
            run_x = XW'(wp) - XW'(rp);
          end else if (capx > XW'(rp)) begin
            run_x = capx - XW'(rp);
          end else begin
            run_x = '0;
          end
        end
      end
      default: begin
      end
    endcase
    s1_next.run_length    = run_x[cfp_pkg::LEN_W-1:0];
    s1_next.fill_level    = cfp_pkg::LEN_W'(XW'(occ_next));
    s1_next.overflow_seen = ovf_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      occ <= '0;
      ovf <= 1'b0;
      cap <= CW'(DEPTH);
    end else if (cfg_wr_en) begin
      wp  <= '0;
      rp  <= '0;
      occ <= '0;
      ovf <= 1'b0;
      cap <= cfg_cap;
    end else if (accept) begin
      wp  <= wp_next;
      rp  <= rp_next;
      occ <= occ_next;
      ovf <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

  cfp_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept && ram_we),
    .waddr (wp),
    .wdata (data_in),
    .re    (accept && ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

endmodule

`default_nettype wire

// ===== src/circular_fifo_with_peek_top.sv =====
// circular_fifo_with_peek_top: ring buffer fifo with peek, discard and run query
// depends on cfp_pkg, cfp_if, cfp_ctrl (which holds cfp_ram)
//
//   channel | direction | handshake     | payload
//   req     | in        | valid/ready   | command, data_in, offset, count
//   rsp     | out       | valid/ready   | status, data_out, run_length, fill_level,
//           |           |               | overflow_seen
//   cfg     | in        | cfg_wr_en     | cfg_wr_data (capacity)
//
// one command per cycle sustained while rsp does not stall; the result passes the decode register,
// which holds the registered ram read, and then the result register that drives rsp.valid
// rst is synchronous: pointers and occupancy cleared, capacity back to DEPTH
// slot contents are not cleared, a slot is only read after it was written
// a stalled rsp holds its result; req keeps flowing while the decode stage can drain
`default_nettype none

module circular_fifo_with_peek_top #(
  parameter int DEPTH         = 256,
  parameter int ELEMENT_WIDTH = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [cfp_pkg::CAP_W-1:0] cfg_wr_data,
  cfp_req_if.sink                        req,
  cfp_rsp_if.source                      rsp
);

  cfp_pkg::s1_t             s1;
  logic [ELEMENT_WIDTH-1:0] rd_data;
  logic                     s1_valid;
  logic                     s1_move;
  logic                     out_valid;
  logic                     accept;

  // decode stage drains when the result register is empty or being taken
  assign s1_move   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_move;
  assign accept    = req.valid && req.ready;
  assign rsp.valid = out_valid;

  cfp_ctrl #(
    .DEPTH         (DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .command     (req.command),
    .data_in     (req.data_in),
    .offset      (req.offset),
    .count       (req.count),
    .s1          (s1),
    .rd_data     (rd_data)
  );

  // valid of the decode stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload; ram data only counts for pop and peek
  always_ff @(posedge clk) begin
    if (s1_move) begin
      rsp.status        <= s1.status;
      rsp.data_out      <= s1.rd ? rd_data : '0;
      rsp.run_length    <= s1.run_length;
      rsp.fill_level    <= s1.fill_level;
      rsp.overflow_seen <= s1.overflow_seen;
    end
  end

endmodule

`default_nettype wire

// ===== src/cfp_checker.sv =====
// cfp_checker: port-level assertions for circular_fifo_with_peek_top, and its bind
// depends on cfp_pkg
`default_nettype none

module cfp_checker #(
  parameter int ELEMENT_WIDTH = 8
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_ready,
  input wire cfp_pkg::result_code_t       rsp_status,
  input wire logic [ELEMENT_WIDTH-1:0]    rsp_data_out,
  input wire logic [cfp_pkg::LEN_W-1:0]   rsp_run_length,
  input wire logic [cfp_pkg::LEN_W-1:0]   rsp_fill_level,
  input wire logic                        rsp_overflow_seen
);

  // a stalled result keeps its status, data and fill level
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_data_out)
      && $stable(rsp_fill_level))
    else $error("result changed while stalled");

  // a refused push always leaves the sticky flag set
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == cfp_pkg::ST_OVERFLOW |-> rsp_overflow_seen)
    else $error("overflow status without overflow flag");

  // failed commands return no data and no run
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != cfp_pkg::ST_OK |-> rsp_data_out == '0 && rsp_run_length == '0)
    else $error("failed command returned data");

  // a run never exceeds the stored elements and excludes element data
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_run_length != '0 |-> rsp_run_length <= rsp_fill_level
      && rsp_data_out == '0)
    else $error("run length out of bounds");

endmodule

bind circular_fifo_with_peek_top cfp_checker #(
  .ELEMENT_WIDTH (ELEMENT_WIDTH)
) u_cfp_checker (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_data_out      (rsp.data_out),
  .rsp_run_length    (rsp.run_length),
  .rsp_fill_level    (rsp.fill_level),
  .rsp_overflow_seen (rsp.overflow_seen)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// testbench for circular_fifo_with_peek_top: directed and random commands against a shadow fifo
// depends on cfp_pkg, cfp_if and the rtl under src
`timescale 1ns / 100ps

module testbench;
  import cfp_pkg::*;

  localparam int DEPTH         = 256;
  localparam int ELEMENT_WIDTH = 8;
  localparam int CYCLE_LIMIT   = 150000;
  localparam int LONG_HOLD     = 150;

  // one command transaction
  typedef struct {
    logic [CMD_W-1:0]         command;
    logic [ELEMENT_WIDTH-1:0] data_in;
    logic [OFFSET_W-1:0]      offset;
    logic [COUNT_W-1:0]       count;
  } cmd_item_t;

  // one result transaction
  typedef struct {
    result_code_t             status;
    logic [ELEMENT_WIDTH-1:0] data_out;
    logic [LEN_W-1:0]         run_length;
    logic [LEN_W-1:0]         fill_level;
    logic                     overflow_seen;
  } reply_t;

  // shadow copy of the fifo: slots, pointers, fill and the capacity register,
  // plus the replies that the rtl still owes
  class fifo_shadow;
    logic [ELEMENT_WIDTH-1:0] slot_mem [DEPTH];
    int unsigned              wr_pos;
    int unsigned              rd_pos;
    int unsigned              fill;
    bit                       overflow;
    logic [CAP_W-1:0]         cap_reg;
    reply_t                   awaited[$];
    int unsigned              errors;

    function new();
      cap_reg = CAP_W'(DEPTH);
      errors  = 0;
      clear();
    endfunction

    function void clear();
      wr_pos   = 0;
      rd_pos   = 0;
      fill     = 0;
      overflow = 1'b0;
    endfunction

    // zero acts as one, anything above the storage depth as the depth
    function int unsigned eff_cap();
      if (cap_reg == 0) return 1;
      if (cap_reg > DEPTH) return DEPTH;
      return cap_reg;
    endfunction

    function int unsigned wrap_add(int unsigned pos, int unsigned n);
      int unsigned p;
      p = pos + n;
      if (p >= eff_cap()) p -= eff_cap();
      return p % DEPTH;
    endfunction

    // a capacity write empties the buffer like a flush
    function void set_capacity(logic [CAP_W-1:0] v);
      cap_reg = v;
      clear();
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // works out the reply of an accepted command and updates the shadow state
    function void take_command(cmd_item_t c);
      reply_t      r;
      int unsigned cap;
      cap          = eff_cap();
      r.status     = ST_OK;
      r.data_out   = '0;
      r.run_length = '0;
      case (c.command)
        CMD_PUSH: begin
          if (fill >= cap) begin
            overflow = 1'b1;
            r.status = ST_OVERFLOW;
          end else begin
            slot_mem[wr_pos] = c.data_in;
            wr_pos = wrap_add(wr_pos, 1);
            fill++;
          end
        end
        CMD_POP: begin
          if (fill == 0) begin
            r.status = ST_UNDERFLOW;
          end else begin
            r.data_out = slot_mem[rd_pos];
            rd_pos = wrap_add(rd_pos, 1);
            fill--;
          end
        end
        CMD_PEEK: begin
          if (fill <= c.offset) r.status = ST_UNDERFLOW;
          else r.data_out = slot_mem[wrap_add(rd_pos, c.offset)];
        end
        CMD_FLUSH: clear();
        CMD_DISCARD: begin
          if (c.count > fill) begin
            r.status = ST_UNDERFLOW;
          end else if (c.count != 0) begin
            rd_pos = wrap_add(rd_pos, c.count);
            fill -= c.count;
          end
        end
        CMD_RUN: begin
          if (fill != 0) begin
            if (wr_pos > rd_pos) r.run_length = LEN_W'(wr_pos - rd_pos);
            else if (cap > rd_pos) r.run_length = LEN_W'(cap - rd_pos);
          end
        end
        default: ;
      endcase
      r.fill_level    = LEN_W'(fill);
      r.overflow_seen = overflow;
      awaited.push_back(r);
    endfunction

    function void report(string field, int unsigned want, logic [LEN_W-1:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d data %0d fill %0d",
                 $time, got.status, got.data_out, got.fill_level);
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.data_out !== want.data_out) report("data_out", want.data_out, got.data_out);
      if (got.run_length !== want.run_length)
        report("run_length", want.run_length, got.run_length);
      if (got.fill_level !== want.fill_level)
        report("fill_level", want.fill_level, got.fill_level);
      if (got.overflow_seen !== want.overflow_seen)
        report("overflow_seen", want.overflow_seen, got.overflow_seen);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;

  cfp_req_if #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) req_ch ();
  cfp_rsp_if #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) rsp_ch ();

  circular_fifo_with_peek_top #(
    .DEPTH(DEPTH),
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  fifo_shadow  shadow;
  int unsigned cycle_count  = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  // long receiver holds: the sender asks, the receiver counts them out
  int unsigned hold_asked   = 0;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random back-pressure, plus a long hold when one is asked
  initial begin : rsp_side
    int unsigned hold_done;
    hold_done = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        rsp_ch.ready <= 1'b0;
        // input keeps flowing meanwhile, so the block fills and stalls req
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // result monitor and run limit
  always @(posedge clk) begin : rsp_monitor
    reply_t seen;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      seen.status        = rsp_ch.status;
      seen.data_out      = rsp_ch.data_out;
      seen.run_length    = rsp_ch.run_length;
      seen.fill_level    = rsp_ch.fill_level;
      seen.overflow_seen = rsp_ch.overflow_seen;
      shadow.check_reply(seen);
    end
  end

  function automatic cmd_item_t cmd_of(logic [CMD_W-1:0] command,
                                       logic [ELEMENT_WIDTH-1:0] data_in,
                                       logic [OFFSET_W-1:0] offset,
                                       logic [COUNT_W-1:0] count);
    cmd_item_t c;
    c.command = command;
    c.data_in = data_in;
    c.offset  = offset;
    c.count   = count;
    return c;
  endfunction

  // random command biased by the current shadow fill so that most peeks and
  // discards land in range and small capacities wrap and overflow often
  function automatic cmd_item_t pick_command(int push_pct);
    cmd_item_t   c;
    int          r;
    int          k;
    int unsigned occ;
    occ = shadow.fill;
    c = cmd_of(CMD_PUSH, ELEMENT_WIDTH'($urandom_range(0, 255)),
               OFFSET_W'($urandom_range(0, 255)), COUNT_W'($urandom_range(0, 511)));
    if ($urandom_range(0, 99) < push_pct) return c;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      c.command = CMD_POP;
    end else if (r < 62) begin
      c.command = CMD_PEEK;
      if (occ > 0 && $urandom_range(0, 3) != 0)
        c.offset = OFFSET_W'($urandom_range(0, (occ > 256) ? 255 : occ - 1));
    end else if (r < 67) begin
      c.command = CMD_FLUSH;
    end else if (r < 82) begin
      c.command = CMD_DISCARD;
      k = $urandom_range(0, 9);
      if (k < 6) c.count = COUNT_W'($urandom_range(0, occ));
      else if (k < 8) c.count = COUNT_W'(occ + 1);
    end else if (r < 94) begin
      c.command = CMD_RUN;
    end else begin
      // unused codes, no operation
      c.command = CMD_W'($urandom_range(6, 7));
    end
    return c;
  endfunction

  // offers one command and waits for its transaction
  task automatic send_command(input cmd_item_t c);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.command <= c.command;
    req_ch.data_in <= c.data_in;
    req_ch.offset  <= c.offset;
    req_ch.count   <= c.count;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    shadow.take_command(c);
  endtask

  // stop offering and wait for every owed result
  task automatic drain_replies();
    req_ch.valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  // capacity is only written while the block is idle
  task automatic write_capacity(input logic [CAP_W-1:0] v);
    drain_replies();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow.set_capacity(v);
  endtask

  // cap_value below zero keeps the current capacity
  task automatic run_segment(input int cap_value, input int n_items, input int push_pct,
                             input int idle_mode, input bit long_hold);
    case (idle_mode)
      0: begin
        snd_idle_pct = 27;
        rcv_idle_pct = 51;
      end
      1: begin
        snd_idle_pct = 51;
        rcv_idle_pct = 27;
      end
      default: begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
    endcase
    if (cap_value >= 0) write_capacity(CAP_W'(cap_value));
    if (long_hold) hold_asked++;
    repeat (n_items) send_command(pick_command(push_pct));
  endtask

  initial begin : stimulus
    shadow = new();
    rst            <= 1'b1;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.command <= CMD_FLUSH;
    req_ch.data_in <= '0;
    req_ch.offset  <= '0;
    req_ch.count   <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty buffer corner cases at the reset capacity
    snd_idle_pct = 27;
    rcv_idle_pct = 51;
    send_command(cmd_of(CMD_POP, 8'h00, 8'd0, 9'd0));       // pop on empty
    send_command(cmd_of(CMD_PEEK, 8'h00, 8'd0, 9'd0));      // peek on empty
    send_command(cmd_of(CMD_DISCARD, 8'h00, 8'd0, 9'd1));   // discard past fill
    send_command(cmd_of(CMD_DISCARD, 8'h00, 8'd0, 9'd0));   // discard of nothing
    send_command(cmd_of(CMD_RUN, 8'h00, 8'd0, 9'd0));       // run query on empty
    // data extremes, peek in and out of range
    send_command(cmd_of(CMD_PUSH, 8'h00, 8'd0, 9'd0));
    send_command(cmd_of(CMD_PUSH, 8'hff, 8'hff, 9'h1ff));
    send_command(cmd_of(CMD_PUSH, 8'h5a, 8'd0, 9'd0));
    send_command(cmd_of(CMD_PEEK, 8'h00, 8'd0, 9'd0));
    send_command(cmd_of(CMD_PEEK, 8'h00, 8'd2, 9'd0));
    send_command(cmd_of(CMD_PEEK, 8'h00, 8'd3, 9'd0));      // offset equals fill
    send_command(cmd_of(CMD_PEEK, 8'h00, 8'd255, 9'd0));
    send_command(cmd_of(CMD_RUN, 8'h00, 8'd0, 9'd0));
    send_command(cmd_of(CMD_POP, 8'h00, 8'd0, 9'd0));
    send_command(cmd_of(CMD_DISCARD, 8'h00, 8'd0, 9'd256)); // count far past the fill
    send_command(cmd_of(CMD_DISCARD, 8'h00, 8'd0, 9'd2));
    send_command(cmd_of(3'd6, 8'h00, 8'd0, 9'd0));          // unused codes
    send_command(cmd_of(3'd7, 8'hff, 8'hff, 9'h1ff));
    send_command(cmd_of(CMD_PUSH, 8'h33, 8'd0, 9'd0));
    send_command(cmd_of(CMD_FLUSH, 8'h00, 8'd0, 9'd0));
    // smallest capacity: refused push, sticky flag, flush clears it
    write_capacity(9'd1);
    send_command(cmd_of(CMD_PUSH, 8'hc3, 8'd0, 9'd0));
    send_command(cmd_of(CMD_PUSH, 8'h11, 8'd0, 9'd0));
    send_command(cmd_of(CMD_RUN, 8'h00, 8'd0, 9'd0));
    send_command(cmd_of(CMD_POP, 8'h00, 8'd0, 9'd0));
    send_command(cmd_of(CMD_FLUSH, 8'h00, 8'd0, 9'd0));

    // random part: receiver idles more first, then the sender, then neither
    run_segment(4, 120, 45, 0, 1'b0);
    run_segment(0, 40, 45, 0, 1'b0);           // zero acts as one
    run_segment(511, 262, 100, 0, 1'b1);       // above depth: fill to overflow under a hold
    run_segment(-1, 80, 20, 1, 1'b0);          // drain the full buffer
    run_segment(7, 100, 45, 1, 1'b0);
    run_segment(256, 60, 55, 1, 1'b0);
    run_segment(300, 40, 50, 2, 1'b0);
    run_segment(13, 110, 45, 2, 1'b1);
    run_segment($urandom_range(2, 20), 60, 45, 2, 1'b0);

    drain_replies();
    // room for any stray result after the last one
    repeat (10) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
